[rtl/core/rcfp_pkg.sv]
package rcfp_pkg;

  localparam int NUM_CHANNELS  = 16;
  localparam int CHAN_W        = 11;
  localparam int CHAN_IDX_W    = 4;
  localparam int PAYLOAD_BYTES = 22;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int COUNT_W       = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 11;

  localparam logic [7:0] FRAME_LEN_CODE = 8'd24;
  localparam logic [7:0] CRC_POLY       = 8'hD5;

  localparam logic [7:0]        SYNC_ADDR_RST   = 8'hC8;
  localparam logic [7:0]        FRAME_TYPE_RST  = 8'h16;
  localparam logic [CHAN_W-1:0] CENTER_VAL_RST  = 11'd1024;

  localparam logic [COUNT_W-1:0]    LAST_BYTE_CNT = COUNT_W'(PAYLOAD_BYTES);
  localparam logic [CHAN_IDX_W-1:0] LAST_CHAN     = CHAN_IDX_W'(NUM_CHANNELS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_ADDR  = 2'd0,
    CFG_FRAME_TYPE = 2'd1,
    CFG_CENTER_VAL = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAGE_HUNT = 2'd0,
    STAGE_LEN  = 2'd1,
    STAGE_TYPE = 2'd2,
    STAGE_BODY = 2'd3
  } parse_stage_t;

  typedef enum logic [1:0] {
    MOTOR_NONE = 2'd0,
    MOTOR_FWD  = 2'd1,
    MOTOR_REV  = 2'd2
  } motor_t;

  // one complete frame handed from the parser to the result unit
  typedef struct packed {
    logic                 crc_ok;
    motor_t               motor;
    logic [PAYLOAD_W-1:0] payload;
  } frame_job_t;

  // crc-8, msb first, eight bit steps
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/rcfp_front.sv]
module rcfp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  input  logic [7:0]                sync_address,
  input  logic [7:0]                frame_type,
  input  logic [rcfp_pkg::CHAN_W-1:0] center_value,
  output logic                      push,
  output rcfp_pkg::frame_job_t      push_job,
  input  logic                      q_full
);
  import rcfp_pkg::*;

  parse_stage_t         stage, stage_next;
  logic [COUNT_W-1:0]   byte_count, byte_count_next;
  logic [7:0]           running_crc, running_crc_next;
  logic [PAYLOAD_W-1:0] payload;
  logic                 shift_en;
  logic                 crc_byte;
  logic                 accept;
  logic [CHAN_W-1:0]    chan1;

  // only the crc byte needs room in the queue
  assign crc_byte = (stage == STAGE_BODY) && (byte_count == LAST_BYTE_CNT);
  assign in_stall = crc_byte && q_full;
  assign accept   = in_valid && !in_stall;
  assign chan1    = payload[CHAN_W +: CHAN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= STAGE_HUNT;
      byte_count  <= '0;
      running_crc <= '0;
    end else begin
      stage       <= stage_next;
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
    end
  end

  // first payload byte ends up in the low bits
  always_ff @(posedge clk) begin
    if (shift_en) begin
      payload <= {rx_byte, payload[PAYLOAD_W-1:8]};
    end
  end

  always_comb begin
    stage_next       = stage;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    shift_en         = 1'b0;
    push             = 1'b0;
    push_job.crc_ok  = (rx_byte == running_crc);
    push_job.payload = payload;
    if (chan1 > center_value) begin
      push_job.motor = MOTOR_FWD;
    end else if (chan1 < center_value) begin
      push_job.motor = MOTOR_REV;
    end else begin
      push_job.motor = MOTOR_NONE;
    end
    if (accept) begin
      unique case (stage)
        STAGE_HUNT: begin
          if (rx_byte == sync_address) begin
            stage_next = STAGE_LEN;
          end
        end
        STAGE_LEN: begin
          if (rx_byte == FRAME_LEN_CODE) begin
            stage_next = STAGE_TYPE;
          end else begin
            stage_next       = (rx_byte == sync_address) ? STAGE_LEN : STAGE_HUNT;
            byte_count_next  = '0;
            running_crc_next = '0;
          end
        end
        STAGE_TYPE: begin
          byte_count_next = '0;
          if (rx_byte == frame_type) begin
            stage_next       = STAGE_BODY;
            running_crc_next = crc8_update(8'h00, rx_byte);
          end else begin
            stage_next       = (rx_byte == sync_address) ? STAGE_LEN : STAGE_HUNT;
            running_crc_next = '0;
          end
        end
        STAGE_BODY: begin
          if (byte_count < LAST_BYTE_CNT) begin
            shift_en         = 1'b1;
            running_crc_next = crc8_update(running_crc, rx_byte);
            byte_count_next  = byte_count + 1'b1;
          end else begin
            push             = 1'b1;
            stage_next       = STAGE_HUNT;
            byte_count_next  = '0;
            running_crc_next = '0;
          end
        end
        default: begin
          stage_next = STAGE_HUNT;
        end
      endcase
    end
  end

endmodule

[rtl/core/rcfp_queue.sv]
module rcfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rcfp_pkg::frame_job_t push_job,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output rcfp_pkg::frame_job_t pop_job
);
  import rcfp_pkg::*;

  frame_job_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

[rtl/core/rcfp_back.sv]
module rcfp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  rcfp_pkg::frame_job_t          q_job,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [rcfp_pkg::CHAN_IDX_W-1:0] channel_index,
  output logic [rcfp_pkg::CHAN_W-1:0]   channel_value,
  output logic [1:0]                    motor_command,
  output logic                          last
);
  import rcfp_pkg::*;

  logic                  active;
  frame_job_t            job;
  logic [CHAN_IDX_W-1:0] chan;
  logic                  produce;
  logic                  is_final;

  // output register free when empty or being taken this cycle
  assign produce  = active && (!out_valid || !out_stall);
  assign is_final = !job.crc_ok || (chan == LAST_CHAN);
  assign q_pop    = q_valid && (!active || (produce && is_final));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (produce && is_final) begin
        active <= 1'b0;
      end
      if (produce) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a new frame replaces the finished one on the edge of its final result
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_job;
      chan <= '0;
    end else if (produce) begin
      job.payload <= job.payload >> CHAN_W;
      chan        <= chan + 1'b1;
    end
    if (produce) begin
      status        <= !job.crc_ok;
      channel_index <= job.crc_ok ? chan : '0;
      channel_value <= job.crc_ok ? job.payload[CHAN_W-1:0] : '0;
      motor_command <= job.crc_ok ? job.motor : MOTOR_NONE;
      last          <= is_final;
    end
  end

endmodule

[rtl/core/rc_channel_frame_parser_core.sv]
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  rx_byte
// out       output     out_valid/out_stall  status, channel_index, channel_value,
//                                           motor_command, last
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one byte per cycle is taken while in_stall is low; a good frame gives sixteen results
// from the result unit, a bad crc gives one. frames wait in a two-entry queue.
// the only input stall is on a crc byte while the queue is full.
// synchronous reset clears the parser stage, the queue and the output valid.
// configuration is always ready.
module rc_channel_frame_parser_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            status,
  output logic [rcfp_pkg::CHAN_IDX_W-1:0] channel_index,
  output logic [rcfp_pkg::CHAN_W-1:0]     channel_value,
  output logic [1:0]                      motor_command,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcfp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcfp_pkg::*;

  logic [7:0]        sync_address;
  logic [7:0]        frame_type;
  logic [CHAN_W-1:0] center_value;
  logic              push;
  frame_job_t        push_job;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  frame_job_t        q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_address <= SYNC_ADDR_RST;
      frame_type   <= FRAME_TYPE_RST;
      center_value <= CENTER_VAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC_ADDR:  sync_address <= cfg_data[7:0];
        CFG_FRAME_TYPE: frame_type   <= cfg_data[7:0];
        CFG_CENTER_VAL: center_value <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  rcfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .sync_address (sync_address),
    .frame_type   (frame_type),
    .center_value (center_value),
    .push         (push),
    .push_job     (push_job),
    .q_full       (q_full)
  );

  rcfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  rcfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_job         (q_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .motor_command (motor_command),
    .last          (last)
  );

endmodule
